[rtl/rccf_pkg.sv]
// Shared constants, types and the raised-cosine weight table for the color crossfade.
package rccf_pkg;

  // Ratio t/T is quantized to EASE_N steps; EASE_N is a power of two.
  localparam int unsigned EASE_LOG2 = 8;
  localparam int unsigned EASE_N    = 1 << EASE_LOG2;
  localparam int unsigned EASE_HALF = EASE_N / 2;
  localparam int unsigned KW        = EASE_LOG2 + 1;          // k holds 0..EASE_N
  localparam int unsigned HIW       = $clog2(EASE_HALF + 1);  // half table index

  localparam int unsigned WW        = 17;                     // weight, Q1.16
  localparam logic [WW-1:0] W_ONE   = 17'h10000;
  localparam logic [63:0]   PI_Q30  = 64'd3373259426;

  // Config register indexes.
  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_BACK     = 2'd1,
    REG_FRONT    = 2'd2,
    REG_ANIM     = 2'd3
  } cfg_reg_e;

  typedef logic [15:0] half_tab_t [EASE_HALF+1];

  // Result of the ratio unit.
  typedef struct packed {
    logic          done;
    logic          over;   // elapsed strictly above the duration
    logic [KW-1:0] k;
  } ratio_res_t;

  // (1 - cos(pi*k/N)) / 2 for 2k <= N, by a ten-term series in Q2.30.
  function automatic logic [15:0] half_weight(int unsigned k);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        w;
    logic signed [63:0] sum;
    theta = (PI_Q30 * 64'(k)) / EASE_N;
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = '0;
    for (int n = 1; n <= 10; n++) begin
      term = (term * t2) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum + $signed(term);
      end else begin
        sum = sum - $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    w = (64'(sum) + 64'd16384) >> 15;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return w[15:0];
  endfunction

  function automatic half_tab_t build_half_tab();
    half_tab_t t;
    for (int unsigned k = 0; k <= EASE_HALF; k++) begin
      t[k] = half_weight(k);
    end
    return t;
  endfunction

  localparam half_tab_t HALF_TAB = build_half_tab();

  // Full weight, mirrored about the midpoint.
  function automatic logic [WW-1:0] ease_weight(logic [KW-1:0] k);
    logic [KW-1:0] m;
    m = KW'(EASE_N) - k;
    if (k <= KW'(EASE_HALF)) begin
      return {1'b0, HALF_TAB[k[HIW-1:0]]};
    end
    return W_ONE - {1'b0, HALF_TAB[m[HIW-1:0]]};
  endfunction

endpackage

[rtl/rccf_ratio.sv]
// Iterative compare-subtract unit: k = min(floor(elapsed * N / duration), N).
module rccf_ratio #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TIME_BITS-1:0]   elapsed_i,
  input  logic [31:0]            dur_i,      // nonzero
  output rccf_pkg::ratio_res_t   res_o
);

  localparam int unsigned CmpW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned CntW = (rccf_pkg::EASE_LOG2 > 1) ? $clog2(rccf_pkg::EASE_LOG2) : 1;

  logic                    busy_q;
  logic                    done_q;
  logic                    over_q;
  logic [CntW-1:0]         cnt_q;
  logic [31:0]             rem_q;
  logic [rccf_pkg::KW-1:0] quo_q;

  logic [CmpW-1:0] e_w;
  logic [CmpW-1:0] d_w;
  logic [32:0]     rem2;
  logic            take;

  assign e_w  = CmpW'(elapsed_i);
  assign d_w  = CmpW'(dur_i);
  assign rem2 = {rem_q, 1'b0};
  assign take = rem2 >= {1'b0, dur_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      over_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        over_q <= e_w > d_w;
        quo_q  <= '0;
        if (e_w >= d_w) begin
          quo_q  <= rccf_pkg::KW'(rccf_pkg::EASE_N);
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(rccf_pkg::EASE_LOG2 - 1);
        end
      end else if (busy_q) begin
        quo_q <= {quo_q[rccf_pkg::KW-2:0], take};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Remainder stays below the duration, so 32 bits suffice.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= e_w[31:0];
    end else if (busy_q) begin
      rem_q <= take ? 32'(rem2 - {1'b0, dur_i}) : rem2[31:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.over = over_q;
  assign res_o.k    = quo_q;

endmodule

[rtl/rccf_mix.sv]
// Shared channel blend: old + floor((target - old) * w / 2^16).
module rccf_mix (
  input  logic [7:0]              old_i,
  input  logic [7:0]              tgt_i,
  input  logic [rccf_pkg::WW-1:0] weight_i,
  output logic [7:0]              mix_o
);

  logic signed [8:0]  diff;
  logic signed [26:0] prod;
  logic signed [10:0] sum;

  assign diff  = $signed({1'b0, tgt_i}) - $signed({1'b0, old_i});
  assign prod  = diff * $signed({1'b0, weight_i});
  // old*(1-w) + tgt*w == old*2^16 + diff*w, so the floor moves onto the product.
  assign sum   = $signed({3'b000, old_i}) + prod[26:16];
  assign mix_o = sum[7:0];

endmodule

[rtl/raised_cosine_color_crossfade.sv]
// Top level of the raised-cosine crossfade over four packed RGB colors.
//
// Input stream (s_axis): one transaction per display frame. The first one after
// reset captures the four start colors and returns them with ongoing set. Later
// ones add frame_time to the elapsed counter (saturating at TIME_BITS), form the
// eased weight and blend twelve 8-bit channels toward the targets.
// Output stream (m_axis): one transaction per input transaction, colors in
// tdata and ongoing in tuser. After the fade has ended every frame returns the
// held colors with ongoing low.
// Config port: cfg_index_i selects fade_duration, back, front or anim target;
// writes are always accepted and belong to idle periods.
// Sequence: a frame inside the fade goes from acceptance to output valid
// through a ratio-unit start, eight compare-subtract steps (one per bit
// of the table index), a table read, twelve passes of the shared channel
// multiplier and a load of the output register. A frame at or past the
// duration skips the eight steps; start and finished frames skip the ratio
// unit and blend. s_axis_tready is high only while the sequencer is idle,
// so a frame is taken only after the last one reaches the output register;
// if the receiver stalls, the next frame is still accepted and computed and
// waits until that register is taken. Reset clears counter, phase, shown colors.
module raised_cosine_color_crossfade #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_time[31:0], start_back[55:32], start_front[79:56],
  // start_anim[103:80], start_center[127:104]
  input  logic [127:0] s_axis_tdata,

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // back_color[23:0], front_color[47:24], anim_color[71:48], center_color[95:72]
  output logic [95:0]  m_axis_tdata,
  // ongoing[0]
  output logic [0:0]   m_axis_tuser,

  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RATIO,
    ST_BLEND,
    ST_DONE
  } state_e;

  localparam int unsigned SumW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [SumW-1:0] TimeMax = SumW'({TIME_BITS{1'b1}});

  // Config registers; duration resets to 1000000 us
  logic [31:0] dur_q;
  logic [23:0] tgt_back_q;
  logic [23:0] tgt_front_q;
  logic [23:0] tgt_anim_q;

  // Fade state
  state_e                  state_q;
  logic                    started_q;
  logic                    finished_q;
  logic                    run_q;
  logic [TIME_BITS-1:0]    elapsed_q;
  logic [23:0]             origin_q [4];
  logic [23:0]             shown_q  [4];
  logic [rccf_pkg::WW-1:0] w_q;
  logic [1:0]              col_q;
  logic [1:0]              byte_q;
  logic                    ratio_start_q;

  // Output register
  logic        m_valid_q;
  logic [95:0] m_data_q;
  logic        m_user_q;

  logic                 s_fire;
  logic [31:0]          ft;
  logic [SumW-1:0]      sum;
  logic [TIME_BITS-1:0] elapsed_d;
  logic [31:0]          dur_eff;
  rccf_pkg::ratio_res_t ratio_res;
  logic [4:0]           boff;
  logic [7:0]           ch_old;
  logic [7:0]           ch_tgt;
  logic [23:0]          tgt_sel;
  logic [7:0]           ch_mix;
  logic                 out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign ft        = s_axis_tdata[31:0];
  assign sum       = SumW'(elapsed_q) + SumW'(ft);
  assign elapsed_d = (sum > TimeMax) ? TimeMax[TIME_BITS-1:0] : sum[TIME_BITS-1:0];
  assign dur_eff   = (dur_q == '0) ? 32'd1 : dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q       <= 32'd1000000;
      tgt_back_q  <= '0;
      tgt_front_q <= '0;
      tgt_anim_q  <= '0;
    end else if (cfg_valid_i) begin
      case (rccf_pkg::cfg_reg_e'(cfg_index_i))
        rccf_pkg::REG_DURATION: dur_q       <= cfg_data_i;
        rccf_pkg::REG_BACK:     tgt_back_q  <= cfg_data_i[23:0];
        rccf_pkg::REG_FRONT:    tgt_front_q <= cfg_data_i[23:0];
        rccf_pkg::REG_ANIM:     tgt_anim_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  rccf_ratio #(
    .TIME_BITS (TIME_BITS)
  ) u_ratio (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ratio_start_q),
    .elapsed_i (elapsed_q),
    .dur_i     (dur_eff),
    .res_o     (ratio_res)
  );

  // Channel select for the shared blend unit; center fades toward the front target.
  assign boff = {byte_q, 3'b000};
  always_comb begin
    case (col_q)
      2'd0:    tgt_sel = tgt_back_q;
      2'd1:    tgt_sel = tgt_front_q;
      2'd2:    tgt_sel = tgt_anim_q;
      default: tgt_sel = tgt_front_q;
    endcase
  end
  assign ch_old = origin_q[col_q][boff +: 8];
  assign ch_tgt = tgt_sel[boff +: 8];

  rccf_mix u_mix (
    .old_i    (ch_old),
    .tgt_i    (ch_tgt),
    .weight_i (w_q),
    .mix_o    (ch_mix)
  );

  // Start colors, captured on the first frame only.
  always_ff @(posedge clk_i) begin
    if (s_fire && !started_q) begin
      origin_q[0] <= s_axis_tdata[55:32];
      origin_q[1] <= s_axis_tdata[79:56];
      origin_q[2] <= s_axis_tdata[103:80];
      origin_q[3] <= s_axis_tdata[127:104];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_data_q <= {shown_q[3], shown_q[2], shown_q[1], shown_q[0]};
      m_user_q <= run_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      started_q     <= 1'b0;
      finished_q    <= 1'b0;
      run_q         <= 1'b0;
      elapsed_q     <= '0;
      w_q           <= '0;
      col_q         <= '0;
      byte_q        <= '0;
      ratio_start_q <= 1'b0;
      m_valid_q     <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        shown_q[i] <= '0;
      end
    end else begin
      ratio_start_q <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (!started_q) begin
              started_q  <= 1'b1;
              elapsed_q  <= '0;
              run_q      <= 1'b1;
              shown_q[0] <= s_axis_tdata[55:32];
              shown_q[1] <= s_axis_tdata[79:56];
              shown_q[2] <= s_axis_tdata[103:80];
              shown_q[3] <= s_axis_tdata[127:104];
              state_q    <= ST_DONE;
            end else if (finished_q) begin
              run_q   <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              elapsed_q     <= elapsed_d;
              ratio_start_q <= 1'b1;
              state_q       <= ST_RATIO;
            end
          end
        end
        ST_RATIO: begin
          if (ratio_res.done) begin
            w_q        <= rccf_pkg::ease_weight(ratio_res.k);
            run_q      <= !ratio_res.over;
            finished_q <= ratio_res.over;
            col_q      <= '0;
            byte_q     <= '0;
            state_q    <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          shown_q[col_q][boff +: 8] <= ch_mix;
          if (byte_q == 2'd2) begin
            byte_q <= '0;
            col_q  <= col_q + 1'b1;
            if (col_q == 2'd3) begin
              state_q <= ST_DONE;
            end
          end else begin
            byte_q <= byte_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  a_ratio_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ratio_res.done |-> state_q == ST_RATIO)
    else $error("ratio unit finished outside its wait state");

  a_byte_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BLEND |-> byte_q != 2'd3)
    else $error("channel byte index out of range");

  a_weight_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BLEND |-> w_q <= rccf_pkg::W_ONE)
    else $error("weight above one");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> m_valid_q && state_q == ST_IDLE)
    else $error("finished result not posted to output register");

  a_ratio_k_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ratio_res.done |-> ratio_res.k <= rccf_pkg::KW'(rccf_pkg::EASE_N))
    else $error("table index above table size");

endmodule
